[rtl/core/bca_pkg.sv]
// Shared types and constants of the bitmap chunk allocator.
`timescale 1ns / 1ps
package bca_pkg;

    localparam int PAGE_SIZE_W = 17;
    localparam int CHUNK_SIZE_W = 17;
    localparam int HEADER_W = 16;
    localparam int CHUNK_COUNT_W = 9;
    localparam int OFFSET_W = 17;
    localparam int PAGE_IN_W = 4;
    localparam int CFG_DATA_W = 17;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_SIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_COUNT = 2'd3;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE = 1'b1;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_BAD = 2'd2;

    // request as classified by the front end
    typedef struct packed {
        logic                 action;
        logic [PAGE_IN_W-1:0] page;
        logic [OFFSET_W-1:0]  rel;
        logic                 bad;
    } t_req;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_FCHK,
        S_FSPLIT,
        S_FRD,
        S_FWR,
        S_ARD,
        S_ACHK,
        S_MUL,
        S_FIN
    } t_state;

endpackage

[rtl/core/bitmap_chunk_allocator.sv]
// Alloc: scans bitmap words in turn (read, then check), passing each full page,
// then multiplies out the offset. Free: bit-serial divide, check, word split and
// read-modify-write of one word; a free caught by the range check is answered from idle.
// The back end works on one transaction at a time; a two-entry queue
// lets the front accept while the back works. The scan loop sets alloc cost.
// Reset (synchronous, active low): all chunks free, one page open, config
// registers to 4096/64/128/62; bitmap valid flags clear on reset.
`timescale 1ns / 1ps
module bitmap_chunk_allocator
    import bca_pkg::*;
#(
    parameter int MAX_PAGES = 16,
    parameter int MAX_CHUNKS = 256,
    parameter int WORD_BITS = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_action,
    input  logic [PAGE_IN_W-1:0]  i_free_page,
    input  logic [OFFSET_W-1:0]   i_free_offset,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [1:0]            o_status,
    output logic [3:0]            o_out_page,
    output logic [15:0]           o_out_offset,
    output logic [7:0]            o_out_chunk
);

    logic [PAGE_SIZE_W-1:0]   r_page_size;
    logic [CHUNK_SIZE_W-1:0]  r_chunk_size;
    logic [HEADER_W-1:0]      r_header;
    logic [CHUNK_COUNT_W-1:0] r_chunk_count;

    logic q_full, q_push, q_pop, q_valid;
    t_req front_req, q_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_size <= PAGE_SIZE_W'(4096);
            r_chunk_size <= CHUNK_SIZE_W'(64);
            r_header <= HEADER_W'(128);
            r_chunk_count <= CHUNK_COUNT_W'(62);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PAGE_SIZE:   r_page_size <= i_cfg_data;
                CFG_CHUNK_SIZE:  r_chunk_size <= i_cfg_data;
                CFG_HEADER:      r_header <= i_cfg_data[HEADER_W-1:0];
                CFG_CHUNK_COUNT: r_chunk_count <= i_cfg_data[CHUNK_COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    bca_front u_front (
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_action     (i_action),
        .i_free_page  (i_free_page),
        .i_free_offset(i_free_offset),
        .i_page_size  (r_page_size),
        .i_chunk_size (r_chunk_size),
        .i_header     (r_header),
        .i_q_full     (q_full),
        .o_push       (q_push),
        .o_req        (front_req)
    );

    bca_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_req  (front_req),
        .o_full (q_full),
        .i_pop  (q_pop),
        .o_valid(q_valid),
        .o_req  (q_req)
    );

    bca_back #(
        .MAX_PAGES (MAX_PAGES),
        .MAX_CHUNKS(MAX_CHUNKS),
        .WORD_BITS (WORD_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_req        (q_req),
        .o_pop        (q_pop),
        .i_chunk_size (r_chunk_size),
        .i_header     (r_header),
        .i_chunk_count(r_chunk_count),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_status     (o_status),
        .o_out_page   (o_out_page),
        .o_out_offset (o_out_offset),
        .o_out_chunk  (o_out_chunk)
    );

endmodule

[rtl/core/bca_front.sv]
// Front end: accepts transactions and range-checks free requests.
`timescale 1ns / 1ps
module bca_front
    import bca_pkg::*;
(
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic                    i_action,
    input  logic [PAGE_IN_W-1:0]    i_free_page,
    input  logic [OFFSET_W-1:0]     i_free_offset,
    input  logic [PAGE_SIZE_W-1:0]  i_page_size,
    input  logic [CHUNK_SIZE_W-1:0] i_chunk_size,
    input  logic [HEADER_W-1:0]     i_header,
    input  logic                    i_q_full,
    output logic                    o_push,
    output t_req                    o_req
);

    logic [OFFSET_W:0] w_end;
    logic              w_bad;

    assign w_end = {1'b0, i_free_offset} + {1'b0, i_chunk_size};

    always_comb begin
        w_bad = (i_free_offset > i_page_size) || (i_chunk_size == '0) ||
                (i_free_offset < {1'b0, i_header}) ||
                (w_end > {1'b0, i_page_size});
    end

    assign o_ready = !i_q_full;
    assign o_push = i_valid && !i_q_full;

    always_comb begin
        o_req.action = i_action;
        o_req.page = i_free_page;
        o_req.rel = i_free_offset - {1'b0, i_header};
        o_req.bad = (i_action == ACT_FREE) && w_bad;
    end

endmodule

[rtl/core/bca_queue.sv]
// Two-entry queue between front and back end.
`timescale 1ns / 1ps
module bca_queue
    import bca_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_req i_req,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_req o_req
);

    t_req       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_req = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_req;
    end

endmodule

[rtl/core/bca_back.sv]
// Back end: divider, bitmap memory, first-fit scan and result register.
`timescale 1ns / 1ps
module bca_back
    import bca_pkg::*;
#(
    parameter int MAX_PAGES = 16,
    parameter int MAX_CHUNKS = 256,
    parameter int WORD_BITS = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_q_valid,
    input  t_req                     i_req,
    output logic                     o_pop,
    input  logic [CHUNK_SIZE_W-1:0]  i_chunk_size,
    input  logic [HEADER_W-1:0]      i_header,
    input  logic [CHUNK_COUNT_W-1:0] i_chunk_count,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [1:0]               o_status,
    output logic [3:0]               o_out_page,
    output logic [15:0]              o_out_offset,
    output logic [7:0]               o_out_chunk
);

    localparam int WPP = (MAX_CHUNKS + WORD_BITS - 1) / WORD_BITS;
    localparam int DEPTH = MAX_PAGES * WPP;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PIW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int PCW = $clog2(MAX_PAGES + 1);
    localparam int WW = (WPP > 1) ? $clog2(WPP) : 1;
    localparam int NW = $clog2(MAX_CHUNKS);
    localparam int BW = $clog2(MAX_CHUNKS + WORD_BITS + 1);
    localparam int BIW = $clog2(WORD_BITS);
    localparam int DCW = $clog2(OFFSET_W);

    t_state r_state, n_state;

    logic [WORD_BITS-1:0] r_mem [DEPTH];
    logic                 r_vld [DEPTH];
    logic [WORD_BITS-1:0] r_rdata;
    logic                 r_rvld;

    logic [PCW-1:0]          r_pages_open, n_pages_open;
    logic [PIW-1:0]          r_pg, n_pg;
    logic [WW-1:0]           r_wd, n_wd;
    logic [BW-1:0]           r_base, n_base;
    logic [NW-1:0]           r_bitn, n_bitn;
    logic [CHUNK_SIZE_W-1:0] r_rem, n_rem;
    logic [OFFSET_W-1:0]     r_quo, n_quo;
    logic [DCW-1:0]          r_dcnt, n_dcnt;
    logic [15:0]             r_prod, n_prod;
    logic                    r_out_valid, n_out_valid;
    logic [1:0]              r_status, n_status;
    logic [3:0]              r_opage, n_opage;
    logic [15:0]             r_ooff, n_ooff;
    logic [7:0]              r_ochunk, n_ochunk;

    logic [AW-1:0]        w_addr;
    logic                 w_we;
    logic [WORD_BITS-1:0] w_wdata;
    logic [WORD_BITS-1:0] w_word;
    logic [WORD_BITS-1:0] w_masked;
    logic [BIW-1:0]       w_idx;
    logic                 w_found;
    logic [31:0]          w_limit;
    logic [OFFSET_W:0]    w_rem_sh;
    logic                 w_sub;

    assign w_addr = AW'(32'(r_pg) * WPP + 32'(r_wd));
    assign w_word = r_rvld ? r_rdata : '0;
    assign w_limit = (32'(i_chunk_count) > MAX_CHUNKS) ? 32'(MAX_CHUNKS)
                                                       : 32'(i_chunk_count);

    // bits at or past the chunk limit count as used
    always_comb begin
        for (int b = 0; b < WORD_BITS; b++) begin
            w_masked[b] = w_word[b] || ((32'(r_base) + b) >= w_limit);
        end
    end

    always_comb begin
        w_idx = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (!w_masked[b]) w_idx = BIW'(b);
        end
    end

    assign w_found = !(&w_masked);
    assign w_rem_sh = {r_rem, r_quo[OFFSET_W-1]};
    assign w_sub = (w_rem_sh >= {1'b0, i_chunk_size});

    always_comb begin
        n_state = r_state;
        n_pages_open = r_pages_open;
        n_pg = r_pg;
        n_wd = r_wd;
        n_base = r_base;
        n_bitn = r_bitn;
        n_rem = r_rem;
        n_quo = r_quo;
        n_dcnt = r_dcnt;
        n_prod = r_prod;
        n_out_valid = r_out_valid && !i_ready;
        n_status = r_status;
        n_opage = r_opage;
        n_ooff = r_ooff;
        n_ochunk = r_ochunk;
        o_pop = 1'b0;
        w_we = 1'b0;
        w_wdata = w_word;

        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid && !r_out_valid) begin
                    o_pop = 1'b1;
                    n_opage = '0;
                    n_ooff = '0;
                    n_ochunk = '0;
                    if (i_req.action == ACT_ALLOC) begin
                        n_pg = '0;
                        n_wd = '0;
                        n_base = '0;
                        n_state = S_ARD;
                    end else if (i_req.bad ||
                                 32'(i_req.page) >= 32'(r_pages_open)) begin
                        n_status = ST_BAD;
                        n_out_valid = 1'b1;
                    end else begin
                        n_pg = PIW'(i_req.page);
                        n_rem = '0;
                        n_quo = i_req.rel;
                        n_dcnt = '0;
                        n_state = S_DIV;
                    end
                end
            end
            // one quotient bit per cycle
            S_DIV: begin
                n_rem = w_sub ? CHUNK_SIZE_W'(w_rem_sh - {1'b0, i_chunk_size})
                              : CHUNK_SIZE_W'(w_rem_sh);
                n_quo = {r_quo[OFFSET_W-2:0], w_sub};
                n_dcnt = r_dcnt + 1'b1;
                if (32'(r_dcnt) == OFFSET_W - 1) n_state = S_FCHK;
            end
            S_FCHK: begin
                if (r_rem != '0 || 32'(r_quo) >= MAX_CHUNKS) begin
                    n_status = ST_BAD;
                    n_out_valid = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_bitn = NW'(r_quo);
                    n_wd = '0;
                    n_state = S_FSPLIT;
                end
            end
            S_FSPLIT: begin
                if (32'(r_bitn) >= WORD_BITS) begin
                    n_bitn = r_bitn - NW'(WORD_BITS);
                    n_wd = r_wd + 1'b1;
                end else begin
                    n_state = S_FRD;
                end
            end
            S_FRD: n_state = S_FWR;
            S_FWR: begin
                w_we = 1'b1;
                w_wdata = w_word & ~(WORD_BITS'(1) << r_bitn);
                n_status = ST_DONE;
                n_out_valid = 1'b1;
                n_state = S_IDLE;
            end
            S_ARD: begin
                // reaching a page opens it
                if (32'(r_pages_open) <= 32'(r_pg)) n_pages_open = PCW'(32'(r_pg) + 1);
                if (32'(r_base) >= w_limit) begin
                    if (32'(r_pg) == MAX_PAGES - 1) begin
                        n_status = ST_FULL;
                        n_out_valid = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_pg = r_pg + 1'b1;
                        n_wd = '0;
                        n_base = '0;
                    end
                end else begin
                    n_state = S_ACHK;
                end
            end
            S_ACHK: begin
                if (w_found) begin
                    w_we = 1'b1;
                    w_wdata = w_word | (WORD_BITS'(1) << w_idx);
                    n_bitn = NW'(32'(r_base) + 32'(w_idx));
                    n_state = S_MUL;
                end else begin
                    n_wd = r_wd + 1'b1;
                    n_base = r_base + BW'(WORD_BITS);
                    n_state = S_ARD;
                end
            end
            S_MUL: begin
                n_prod = 16'(r_bitn) * i_chunk_size[15:0];
                n_state = S_FIN;
            end
            S_FIN: begin
                n_status = ST_DONE;
                n_opage = 4'(r_pg);
                n_ooff = r_prod + i_header;
                n_ochunk = 8'(r_bitn);
                n_out_valid = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pages_open <= PCW'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_pages_open <= n_pages_open;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pg <= n_pg;
        r_wd <= n_wd;
        r_base <= n_base;
        r_bitn <= n_bitn;
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dcnt <= n_dcnt;
        r_prod <= n_prod;
        r_status <= n_status;
        r_opage <= n_opage;
        r_ooff <= n_ooff;
        r_ochunk <= n_ochunk;
    end

    // bitmap words: an unwritten word reads as all free
    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_addr] <= w_wdata;
        r_rdata <= r_mem[w_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) r_vld[i] <= 1'b0;
            r_rvld <= 1'b0;
        end else begin
            if (w_we) r_vld[w_addr] <= 1'b1;
            r_rvld <= r_vld[w_addr];
        end
    end

    assign o_valid = r_out_valid;
    assign o_status = r_status;
    assign o_out_page = r_opage;
    assign o_out_offset = r_ooff;
    assign o_out_chunk = r_ochunk;

endmodule

[tb/tb_bitmap_chunk_allocator.sv]
// Self-checking testbench for the bitmap chunk allocator with directed and random traffic.
`timescale 1ns / 1ps
module tb_bitmap_chunk_allocator;
    import bca_pkg::*;

    localparam int NUM_PAGES = 16;
    localparam int NUM_CHUNKS = 256;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct {
        logic                 action;
        logic [PAGE_IN_W-1:0] page;
        logic [OFFSET_W-1:0]  offset;
    } t_alloc_req;

    typedef struct {
        logic [1:0]  status;
        logic [3:0]  page;
        logic [15:0] offset;
        logic [7:0]  chunk;
    } t_alloc_res;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_valid;
    logic                  o_ready;
    logic                  i_action;
    logic [PAGE_IN_W-1:0]  i_free_page;
    logic [OFFSET_W-1:0]   i_free_offset;
    logic                  o_valid;
    logic                  i_ready;
    logic [1:0]            o_status;
    logic [3:0]            o_out_page;
    logic [15:0]           o_out_offset;
    logic [7:0]            o_out_chunk;

    bitmap_chunk_allocator dut (.*);

    // allocator state as predicted
    logic [NUM_CHUNKS-1:0] used_map [NUM_PAGES];
    int unsigned           open_pages;
    longint unsigned       page_bytes, chunk_bytes, header_len, chunks_per_page;

    t_alloc_req pending_reqs[$];
    t_alloc_res expected_results[$];
    t_alloc_req cur_req;
    int         errors;
    int         cycles;
    int         burst_left, gap_left, ready_run, ready_mode;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_alloc_res predict_result(t_alloc_req r);
        t_alloc_res      res;
        longint unsigned lim, off, rel;
        res = '{ST_DONE, 4'd0, 16'd0, 8'd0};
        lim = (chunks_per_page > NUM_CHUNKS) ? NUM_CHUNKS : chunks_per_page;
        if (r.action == ACT_ALLOC) begin
            for (int p = 0; p < NUM_PAGES; p++) begin
                if (p >= open_pages) begin
                    used_map[p] = '0;
                    open_pages = p + 1;
                end
                for (int c = 0; c < lim; c++) begin
                    if (!used_map[p][c]) begin
                        used_map[p][c] = 1'b1;
                        off = header_len + longint'(c) * chunk_bytes;
                        res.page = p[3:0];
                        res.offset = off[15:0];
                        res.chunk = c[7:0];
                        return res;
                    end
                end
            end
            res.status = ST_FULL;
            return res;
        end
        off = r.offset;
        if (r.page >= open_pages || off > page_bytes || chunk_bytes == 0 ||
            off < header_len || ((off - header_len) % chunk_bytes) != 0 ||
            off + chunk_bytes > page_bytes) begin
            res.status = ST_BAD;
            return res;
        end
        rel = (off - header_len) / chunk_bytes;
        if (rel >= NUM_CHUNKS) begin
            res.status = ST_BAD;
            return res;
        end
        used_map[r.page][rel] = 1'b0;
        return res;
    endfunction

    // driver: bursts with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                expected_results.push_back(predict_result(cur_req));
            end
            if (!i_valid || o_ready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    i_valid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    cur_req = pending_reqs.pop_front();
                    i_action <= cur_req.action;
                    i_free_page <= cur_req.page;
                    i_free_offset <= cur_req.offset;
                    i_valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 20);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each transaction, stall on a pattern of runs
    always @(posedge i_clk) begin
        t_alloc_res exp_res;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result status=%0d page=%0d offset=%0d chunk=%0d",
                         $time, o_status, o_out_page, o_out_offset, o_out_chunk);
                errors++;
            end else begin
                exp_res = expected_results.pop_front();
                if (o_status !== exp_res.status || o_out_page !== exp_res.page ||
                    o_out_offset !== exp_res.offset || o_out_chunk !== exp_res.chunk) begin
                    $display("%0t: expected status=%0d page=%0d offset=%0d chunk=%0d",
                             $time, exp_res.status, exp_res.page, exp_res.offset,
                             exp_res.chunk);
                    $display("%0t: actual   status=%0d page=%0d offset=%0d chunk=%0d",
                             $time, o_status, o_out_page, o_out_offset, o_out_chunk);
                    errors++;
                end
            end
        end
        if (ready_run <= 0) begin
            ready_mode <= $urandom_range(0, 2);
            ready_run <= $urandom_range(1, 12);
        end else begin
            ready_run <= ready_run - 1;
        end
        case (ready_mode)
            0: i_ready <= 1'b1;
            1: i_ready <= 1'($urandom_range(0, 1));
            default: i_ready <= 1'b0;
        endcase
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic push_req(logic act, logic [3:0] pg, logic [16:0] off);
        pending_reqs.push_back('{act, pg, off});
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_PAGE_SIZE: page_bytes = val;
            CFG_CHUNK_SIZE: chunk_bytes = val;
            CFG_HEADER: header_len = val[15:0];
            CFG_CHUNK_COUNT: chunks_per_page = val[8:0];
            default: ;
        endcase
    endtask

    task automatic set_config(int unsigned ps, int unsigned cs, int unsigned hb,
                              int unsigned cc);
        write_reg(CFG_PAGE_SIZE, CFG_DATA_W'(ps));
        write_reg(CFG_CHUNK_SIZE, CFG_DATA_W'(cs));
        write_reg(CFG_HEADER, CFG_DATA_W'(hb));
        write_reg(CFG_CHUNK_COUNT, CFG_DATA_W'(cc));
    endtask

    task automatic wait_idle();
        while (pending_reqs.size() > 0 || i_valid || expected_results.size() > 0)
            @(posedge i_clk);
    endtask

    // mostly chunk-aligned frees of likely-open pages, some raw noise
    task automatic add_random(int n, int alloc_pct);
        longint unsigned off;
        logic [3:0]      pg;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 99) < alloc_pct) begin
                push_req(ACT_ALLOC, 4'($urandom), 17'($urandom));
            end else if ($urandom_range(0, 9) < 7) begin
                pg = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                                 : 4'($urandom_range(0, 3));
                off = header_len + chunk_bytes *
                      $urandom_range(0, (chunks_per_page > 0) ? chunks_per_page : 1);
                push_req(ACT_FREE, pg, off[16:0]);
            end else begin
                push_req(ACT_FREE, 4'($urandom), 17'($urandom));
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_action = ACT_ALLOC;
        i_free_page = '0;
        i_free_offset = '0;
        i_ready = 1'b0;
        errors = 0;
        cycles = 0;
        burst_left = 0;
        gap_left = 0;
        ready_run = 0;
        ready_mode = 0;
        for (int p = 0; p < NUM_PAGES; p++) used_map[p] = '0;
        open_pages = 1;
        page_bytes = 4096;
        chunk_bytes = 64;
        header_len = 128;
        chunks_per_page = 62;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed on reset values
        push_req(ACT_ALLOC, 4'd0, 17'd0);
        push_req(ACT_ALLOC, 4'hF, 17'h1FFFF);
        push_req(ACT_ALLOC, 4'd0, 17'd0);
        push_req(ACT_FREE, 4'd0, 17'd192);
        push_req(ACT_FREE, 4'd0, 17'd192);
        push_req(ACT_FREE, 4'd5, 17'd128);
        push_req(ACT_FREE, 4'd0, 17'd130);
        push_req(ACT_FREE, 4'd0, 17'd64);
        push_req(ACT_FREE, 4'd0, 17'd4096);
        push_req(ACT_FREE, 4'd0, 17'd4032);
        push_req(ACT_FREE, 4'd0, 17'h1FFFF);
        push_req(ACT_ALLOC, 4'd0, 17'd0);
        push_req(ACT_FREE, 4'd0, 17'd128);
        wait_idle();
        // zero chunk count: every page opens, allocation reports full
        set_config(4096, 64, 128, 0);
        push_req(ACT_ALLOC, 4'd0, 17'd0);
        push_req(ACT_FREE, 4'd15, 17'd128);
        wait_idle();
        // zero chunk size and offset overflow
        set_config(4096, 0, 100, 3);
        push_req(ACT_ALLOC, 4'd0, 17'd0);
        push_req(ACT_FREE, 4'd0, 17'd100);
        wait_idle();
        set_config(65536, 65536, 65535, 511);
        push_req(ACT_ALLOC, 4'd0, 17'd0);
        push_req(ACT_ALLOC, 4'd0, 17'd0);
        push_req(ACT_FREE, 4'd0, 17'd65535);
        wait_idle();

        set_config(4096, 64, 128, 62);
        add_random(220, 60);
        wait_idle();
        set_config(65536, 1, 0, 256);
        add_random(220, 50);
        wait_idle();
        set_config(64, 65536, 65535, 300);
        add_random(120, 50);
        wait_idle();
        set_config(1024, 16, 32, 4);
        add_random(240, 55);
        wait_idle();
        set_config(4096, 64, 0, 0);
        add_random(60, 50);
        wait_idle();
        set_config(512, 0, 100, 3);
        add_random(100, 50);
        wait_idle();
        set_config(65536, 256, 0, 256);
        add_random(220, 65);
        wait_idle();
        set_config(2048, 48, 16, 1);
        add_random(300, 55);
        wait_idle();

        repeat (300) @(posedge i_clk);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
